// ----- rtl/lsrc_pkg.sv -----
// shared types and outcode constants for the line segment clipper
package lsrc_pkg;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EVAL = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_UPD  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    typedef logic [3:0] t_code;

    localparam t_code CODE_ABOVE = 4'b1000;
    localparam t_code CODE_BELOW = 4'b0100;
    localparam t_code CODE_RIGHT = 4'b0010;
    localparam t_code CODE_LEFT  = 4'b0001;

    localparam int MAX_MOVES = 4;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

endpackage

// ----- rtl/line_segment_rect_clipper_top.sv -----
// cohen-sutherland segment clipper with bit-serial multiply and restoring divide
// each edge move runs the shared bit-serial multiplier and then the divider once; a segment
//   needs at most MAX_MOVES edge moves, and a move along a zero extent skips both
// throughput: one item at a time; the next item is taken while a result waits in the
//   output register
// reset: synchronous active low, clears control state and loads the default window
module line_segment_rect_clipper_top #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y from the lowest bit up
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // accepted
    output logic                   o_m_axis_tuser,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [3:0]             i_paddr,
    input  logic [31:0]            i_pwdata,
    output logic [31:0]            o_prdata,
    output logic                   o_pready
);
    import lsrc_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int M    = W + 1;
    localparam int SW   = 2*M + 2;
    localparam int DW   = ((4*W+7)/8)*8;
    localparam int CNTW = $clog2(2*M + 1);
    localparam int SCALE_ONE = 1 << FRAC_BITS;

    localparam logic signed [W-1:0] RST_LEFT   = W'(4 * SCALE_ONE);
    localparam logic signed [W-1:0] RST_RIGHT  = W'(10 * SCALE_ONE);
    localparam logic signed [W-1:0] RST_BOTTOM = W'(4 * SCALE_ONE);
    localparam logic signed [W-1:0] RST_TOP    = W'(8 * SCALE_ONE);

    localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (W-1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    logic signed [W-1:0] r_win_left, r_win_right, r_win_bottom, r_win_top;
    logic signed [W-1:0] r_x1, r_y1, r_x2, r_y2;
    t_state              r_state;
    logic [2:0]          r_moves;
    logic [CNTW-1:0]     r_cnt;
    logic [M-1:0]        r_mcand, r_div, r_rem;
    logic [2*M-1:0]      r_prod;
    logic                r_neg, r_zero, r_vert, r_sel1;
    logic signed [W-1:0] r_base, r_edge;
    logic                r_ovalid, r_oacc;
    logic [DW-1:0]       r_odata;
    logic                r_acc;

    logic                cfg_wr;
    t_code               c1, c2, co;
    logic signed [M-1:0] d_a, d_b, d_c;
    logic [M:0]          mul_sum;
    logic [M:0]          div_try;
    logic                div_ge;
    logic signed [SW-1:0] upd_q, upd_sum;
    logic signed [W-1:0] upd_val;
    logic                eval_done, eval_acc;

    assign o_pready        = 1'b1;
    assign cfg_wr          = i_psel && i_penable && i_pwrite;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_oacc;

    always_comb begin
        unique case (i_paddr[3:2])
            REG_LEFT:   o_prdata = 32'(r_win_left);
            REG_RIGHT:  o_prdata = 32'(r_win_right);
            REG_BOTTOM: o_prdata = 32'(r_win_bottom);
            default:    o_prdata = 32'(r_win_top);
        endcase
    end

    always_comb begin
        c1 = '0;
        c2 = '0;
        if (r_x1 < r_win_left)        c1 |= CODE_LEFT;
        else if (r_x1 > r_win_right)  c1 |= CODE_RIGHT;
        if (r_y1 < r_win_bottom)      c1 |= CODE_BELOW;
        else if (r_y1 > r_win_top)    c1 |= CODE_ABOVE;
        if (r_x2 < r_win_left)        c2 |= CODE_LEFT;
        else if (r_x2 > r_win_right)  c2 |= CODE_RIGHT;
        if (r_y2 < r_win_bottom)      c2 |= CODE_BELOW;
        else if (r_y2 > r_win_top)    c2 |= CODE_ABOVE;
        co = (c1 != '0) ? c1 : c2;
        eval_acc  = (c1 == '0) && (c2 == '0);
        eval_done = eval_acc || ((c1 & c2) != '0) || (r_moves == 3'(MAX_MOVES));
    end

    // operands of the edge intersection for the chosen edge
    always_comb begin
        if ((co & (CODE_ABOVE | CODE_BELOW)) != '0) begin
            d_a = M'(r_x2) - M'(r_x1);
            d_c = M'(r_y2) - M'(r_y1);
            d_b = ((co & CODE_ABOVE) != '0) ? M'(r_win_top) - M'(r_y1)
                                            : M'(r_win_bottom) - M'(r_y1);
        end else begin
            d_a = M'(r_y2) - M'(r_y1);
            d_c = M'(r_x2) - M'(r_x1);
            d_b = ((co & CODE_RIGHT) != '0) ? M'(r_win_right) - M'(r_x1)
                                            : M'(r_win_left) - M'(r_x1);
        end
    end

    assign mul_sum = {1'b0, r_prod[2*M-1:M]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
    assign div_try = {r_rem, r_prod[2*M-1]};
    assign div_ge  = (div_try >= {1'b0, r_div});

    always_comb begin
        upd_q   = r_zero ? '0 : (r_neg ? -SW'(r_prod) : SW'(r_prod));
        upd_sum = SW'(r_base) + upd_q;
        if (upd_sum > SAT_MAX)      upd_val = W'(SAT_MAX);
        else if (upd_sum < SAT_MIN) upd_val = W'(SAT_MIN);
        else                        upd_val = W'(upd_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= RST_LEFT;
            r_win_right  <= RST_RIGHT;
            r_win_bottom <= RST_BOTTOM;
            r_win_top    <= RST_TOP;
        end else if (cfg_wr) begin
            unique case (i_paddr[3:2])
                REG_LEFT:   r_win_left   <= i_pwdata[W-1:0];
                REG_RIGHT:  r_win_right  <= i_pwdata[W-1:0];
                REG_BOTTOM: r_win_bottom <= i_pwdata[W-1:0];
                default:    r_win_top    <= i_pwdata[W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_moves  <= '0;
            r_cnt    <= '0;
        end else begin
            // the finish state sets the output itself
            if (r_ovalid && i_m_axis_tready && (r_state != ST_FIN)) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_x1    <= i_s_axis_tdata[W-1:0];
                        r_y1    <= i_s_axis_tdata[2*W-1:W];
                        r_x2    <= i_s_axis_tdata[3*W-1:2*W];
                        r_y2    <= i_s_axis_tdata[4*W-1:3*W];
                        r_moves <= '0;
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (eval_done) begin
                        r_acc   <= eval_acc;
                        r_state <= ST_FIN;
                    end else begin
                        r_sel1  <= (c1 != '0);
                        r_vert  <= ((co & (CODE_ABOVE | CODE_BELOW)) == '0);
                        r_neg   <= d_a[M-1] ^ d_b[M-1] ^ d_c[M-1];
                        r_zero  <= (d_c == '0);
                        r_mcand <= d_a[M-1] ? M'(-d_a) : M'(d_a);
                        r_div   <= d_c[M-1] ? M'(-d_c) : M'(d_c);
                        r_prod  <= {{M{1'b0}}, (d_b[M-1] ? M'(-d_b) : M'(d_b))};
                        r_rem   <= '0;
                        if ((co & (CODE_ABOVE | CODE_BELOW)) != '0) begin
                            r_base <= (c1 != '0) ? r_x1 : r_x1;
                            r_edge <= ((co & CODE_ABOVE) != '0) ? r_win_top : r_win_bottom;
                        end else begin
                            r_base <= r_y1;
                            r_edge <= ((co & CODE_RIGHT) != '0) ? r_win_right : r_win_left;
                        end
                        r_cnt   <= CNTW'(M);
                        // a segment with no extent across the chosen edge skips the arithmetic
                        r_state <= (d_c == '0) ? ST_UPD : ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod <= {mul_sum, r_prod[M-1:1]};
                    if (r_cnt == CNTW'(1)) begin
                        r_cnt   <= CNTW'(2*M);
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_DIV: begin
                    r_rem  <= div_ge ? M'(div_try - {1'b0, r_div}) : div_try[M-1:0];
                    r_prod <= {r_prod[2*M-2:0], div_ge};
                    if (r_cnt == CNTW'(1)) r_state <= ST_UPD;
                    r_cnt <= r_cnt - 1'b1;
                end
                ST_UPD: begin
                    if (r_sel1) begin
                        if (r_vert) begin r_x1 <= r_edge; r_y1 <= upd_val; end
                        else        begin r_y1 <= r_edge; r_x1 <= upd_val; end
                    end else begin
                        if (r_vert) begin r_x2 <= r_edge; r_y2 <= upd_val; end
                        else        begin r_y2 <= r_edge; r_x2 <= upd_val; end
                    end
                    r_moves <= r_moves + 1'b1;
                    r_state <= ST_EVAL;
                end
                ST_FIN: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oacc   <= r_acc;
                        r_odata  <= r_acc ? DW'({r_y2, r_x2, r_y1, r_x1}) : '0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_moves_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moves <= 3'(MAX_MOVES))
        else $error("more than four edge moves");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div != '0))
        else $error("divide by zero entered");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_oacc) |-> (r_odata == '0))
        else $error("rejected item carries coordinates");

endmodule

// ----- dv/line_segment_rect_clipper_top_tb.sv -----
// self-checking testbench for the segment clipper: table-driven and extreme-window items, then random
`timescale 1ns / 100ps

module line_segment_rect_clipper_top_tb;
    import lsrc_pkg::*;

    localparam int CW = 24;
    localparam int DW = ((4*CW+7)/8)*8;
    localparam logic signed [63:0] C_MAX = (64'sd1 <<< (CW-1)) - 1;
    localparam logic signed [63:0] C_MIN = -(64'sd1 <<< (CW-1));
    localparam int N_RANDOM = 1280;

    typedef struct packed {
        logic signed [CW-1:0] x1, y1, x2, y2;
    } t_seg;

    typedef struct packed {
        logic                 acc;
        logic signed [CW-1:0] x1, y1, x2, y2;
    } t_clip;

    // one directed row: segment, and a typed result where has_exp is set
    typedef struct {
        t_seg  seg;
        bit    has_exp;
        t_clip exp_clip;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_axis_tvalid;
    logic          o_s_axis_tready;
    logic [DW-1:0] i_s_axis_tdata;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready;
    logic [DW-1:0] o_m_axis_tdata;
    logic          o_m_axis_tuser;
    logic          i_psel, i_penable, i_pwrite;
    logic [3:0]    i_paddr;
    logic [31:0]   i_pwdata;
    logic [31:0]   o_prdata;
    logic          o_pready;

    line_segment_rect_clipper_top #(.COORD_WIDTH(CW), .FRAC_BITS(8)) DUT (.*);

    logic signed [63:0] win_l, win_r, win_b, win_t;
    t_clip clip_q[$];
    int    n_err, n_seen, n_acc, n_rej;
    int    src_idle_pct, snk_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("timeout at %0t", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [3:0] region(logic signed [63:0] x, logic signed [63:0] y);
        logic [3:0] c;
        c = 4'b0;
        if (x < win_l) c |= CODE_LEFT;
        else if (x > win_r) c |= CODE_RIGHT;
        if (y < win_b) c |= CODE_BELOW;
        else if (y > win_t) c |= CODE_ABOVE;
        return c;
    endfunction

    // a*b/c truncated toward zero and clamped to +/-2**62, zero for a zero divisor
    function automatic logic signed [63:0] scaled_offset(logic signed [63:0] a,
            logic signed [63:0] b, logic signed [63:0] c);
        logic signed [127:0] p, q;
        if (c == 0) return 0;
        p = 128'(a) * 128'(b);
        q = p / 128'(c);
        if (q > (128'sd1 <<< 62)) return 64'sd1 <<< 62;
        if (q < -(128'sd1 <<< 62)) return -(64'sd1 <<< 62);
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] clamp(logic signed [63:0] v);
        if (v > C_MAX) return C_MAX;
        if (v < C_MIN) return C_MIN;
        return v;
    endfunction

    function automatic t_clip clip_segment(t_seg s);
        logic signed [63:0] x1, y1, x2, y2, x, y;
        logic [3:0] c1, c2, co;
        t_clip r;
        int moves;
        x1 = s.x1; y1 = s.y1; x2 = s.x2; y2 = s.y2;
        c1 = region(x1, y1);
        c2 = region(x2, y2);
        r = '0;
        for (moves = 0; ; moves++) begin
            if (c1 == 0 && c2 == 0) begin
                r.acc = 1'b1;
                break;
            end
            if ((c1 & c2) != 0 || moves == MAX_MOVES) break;
            co = (c1 != 0) ? c1 : c2;
            if (co & CODE_ABOVE) begin
                y = win_t;
                x = clamp(x1 + scaled_offset(x2 - x1, win_t - y1, y2 - y1));
            end else if (co & CODE_BELOW) begin
                y = win_b;
                x = clamp(x1 + scaled_offset(x2 - x1, win_b - y1, y2 - y1));
            end else if (co & CODE_RIGHT) begin
                x = win_r;
                y = clamp(y1 + scaled_offset(y2 - y1, win_r - x1, x2 - x1));
            end else begin
                x = win_l;
                y = clamp(y1 + scaled_offset(y2 - y1, win_l - x1, x2 - x1));
            end
            if (c1 != 0) begin
                x1 = x; y1 = y; c1 = region(x1, y1);
            end else begin
                x2 = x; y2 = y; c2 = region(x2, y2);
            end
        end
        if (r.acc) begin
            r.x1 = x1[CW-1:0]; r.y1 = y1[CW-1:0];
            r.x2 = x2[CW-1:0]; r.y2 = y2[CW-1:0];
        end
        return r;
    endfunction

    // result side: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        t_clip got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.acc = o_m_axis_tuser;
                got.x1 = o_m_axis_tdata[0 +: CW];
                got.y1 = o_m_axis_tdata[CW +: CW];
                got.x2 = o_m_axis_tdata[2*CW +: CW];
                got.y2 = o_m_axis_tdata[3*CW +: CW];
                if (clip_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    n_err++;
                end else begin
                    want = clip_q.pop_front();
                    n_seen++;
                    if (want.acc) n_acc++; else n_rej++;
                    if (got.acc !== want.acc || got.x1 !== want.x1 || got.y1 !== want.y1
                            || got.x2 !== want.x2 || got.y2 !== want.y2) begin
                        $display("%0t: expected acc=%0b %0d,%0d %0d,%0d got acc=%0b %0d,%0d %0d,%0d",
                            $time, want.acc, want.x1, want.y1, want.x2, want.y2,
                            got.acc, got.x1, got.y1, got.x2, got.y2);
                        n_err++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic write_window(logic [1:0] idx, logic signed [63:0] v);
        logic signed [63:0] sv;
        // the block sees only the low coordinate bits, as a signed value
        sv = signed'(v[CW-1:0]);
        i_psel <= 1'b1; i_penable <= 1'b0; i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00}; i_pwdata <= 32'(v[CW-1:0]);
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0; i_penable <= 1'b0; i_pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_LEFT:   win_l = sv;
            REG_RIGHT:  win_r = sv;
            REG_BOTTOM: win_b = sv;
            REG_TOP:    win_t = sv;
        endcase
    endtask

    task automatic set_window(logic signed [63:0] l, r, b, t);
        write_window(REG_LEFT, l);
        write_window(REG_RIGHT, r);
        write_window(REG_BOTTOM, b);
        write_window(REG_TOP, t);
    endtask

    task automatic wait_drained();
        while (clip_q.size() != 0) @(posedge i_clk);
        // output register and clipping engine both settled
        repeat (4*(3*CW+5)+10) @(posedge i_clk);
    endtask

    task automatic send_segment(t_seg s, bit has_exp, t_clip e);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {s.y2, s.x2, s.y1, s.x1};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        clip_q.push_back(has_exp ? e : clip_segment(s));
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($urandom_range(3584) - 512);
            2: return ($urandom_range(1)) ? C_MAX[CW-1:0] : C_MIN[CW-1:0];
            default: return CW'($urandom_range(4096) - 2048);
        endcase
    endfunction

    t_row rows[$];
    t_seg  seg;
    t_clip none;

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0; i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0;
        i_paddr = '0; i_pwdata = '0;
        n_err = 0; n_seen = 0; n_acc = 0; n_rej = 0;
        src_idle_pct = 22; snk_idle_pct = 84;
        win_l = 1024; win_r = 2560; win_b = 1024; win_t = 2048;
        none = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows on the reset window
        rows = '{
            '{'{1536, 1536, 2048, 1792}, 1, '{1'b1, 1536, 1536, 2048, 1792}},
            '{'{1024, 1024, 2560, 2048}, 1, '{1'b1, 1024, 1024, 2560, 2048}},
            '{'{0, 0, 512, 512}, 1, none},
            '{'{0, 3000, 4000, 3000}, 1, none},
            '{'{3000, 0, 3000, 4000}, 1, none},
            '{'{-8388608, -8388608, -8388608, 8388607}, 1, none},
            '{'{8388607, 8388607, 8388607, -8388608}, 1, none},
            '{'{0, 1536, 4000, 1536}, 1, '{1'b1, 1024, 1536, 2560, 1536}},
            '{'{1536, 0, 1536, 4000}, 1, '{1'b1, 1536, 1024, 1536, 2048}},
            '{'{0, 0, 4000, 3000}, 0, none},
            '{'{2000, 3000, 2000, 1500}, 0, none},
            '{'{0, 2000, 5000, 500}, 0, none},
            '{'{500, 2500, 3000, 3000}, 0, none},
            '{'{-8388608, -8388608, 8388607, 8388607}, 0, none},
            '{'{8388607, -8388608, -8388608, 8388607}, 0, none},
            '{'{100, 3100, 3100, 100}, 0, none}
        };
        foreach (rows[i]) send_segment(rows[i].seg, rows[i].has_exp, rows[i].exp_clip);
        wait_drained();

        // extreme windows, including degenerate and inverted ones
        set_window(C_MIN, C_MAX, C_MIN, C_MAX);
        seg = '{-8388608, 8388607, 8388607, -8388608};
        send_segment(seg, 0, none);
        seg = '{0, 0, 0, 0};
        send_segment(seg, 0, none);
        wait_drained();
        set_window(0, 0, 0, 0);
        seg = '{-256, -256, 256, 256};
        send_segment(seg, 0, none);
        seg = '{-256, 0, 256, 0};
        send_segment(seg, 0, none);
        wait_drained();
        set_window(2560, 1024, 2048, 1024);
        seg = '{0, 0, 4000, 3000};
        send_segment(seg, 0, none);
        seg = '{-8388608, 8388607, 8388607, -8388608};
        send_segment(seg, 0, none);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            logic signed [63:0] a, b;
            case (ph % 3)
                0: begin src_idle_pct = 22; snk_idle_pct = 84; end
                1: begin src_idle_pct = 84; snk_idle_pct = 22; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            if (ph == 5) begin
                set_window(1024, 2560, 1024, 2048);
            end else if (ph == 4) begin
                set_window(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
            end else begin
                a = $urandom_range(3000) - 1500; b = $urandom_range(3000) - 1500;
                set_window(a, a + $urandom_range(2000), b, b + $urandom_range(2000));
            end
            for (int n = 0; n < N_RANDOM/6; n++) begin
                int m1, m2;
                m1 = ($urandom_range(9) < 6) ? 1 : $urandom_range(3);
                m2 = ($urandom_range(9) < 6) ? 1 : $urandom_range(3);
                seg = '{rand_coord(m1), rand_coord(m1), rand_coord(m2), rand_coord(m2)};
                if ($urandom_range(19) == 0) seg.x2 = seg.x1;
                if ($urandom_range(19) == 0) seg.y2 = seg.y1;
                send_segment(seg, 0, none);
                if (n == 100) while (clip_q.size() != 0) @(posedge i_clk);
            end
            wait_drained();
        end

        $display("checked %0d clipped segments: %0d accepted, %0d rejected", n_seen, n_acc, n_rej);
        $display("windows covered reset, full range, zero size, inverted and random");
        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lsrc_pkg.sv
rtl/line_segment_rect_clipper_top.sv
dv/line_segment_rect_clipper_top_tb.sv
